// ===== rtl/core/utf16_to_utf8_transcoder_macros.svh =====
// Assertion macros shared by the UTF-16 to UTF-8 transcoder modules.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

`ifndef SYNTHESIS
`define U16U8_ASSERT_IMPLIES(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");
`define U16U8_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define U16U8_ASSERT_IMPLIES(name, clk, rst, pre, post)
`define U16U8_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

// ===== rtl/core/u16u8_pkg.sv =====
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

   localparam int UNIT_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int MAX_BYTES   = 6;
   localparam int JOB_CNT_W   = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_BYTE  = 8'h80;
   localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [JOB_CNT_W-1:0]             cnt;
      logic                             str_end;
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
// The request channel (req_valid, req_ready, req_code_unit) takes one UTF-16
// code unit per request. The result channel (rsp_valid, rsp_ready, rsp_*)
// returns the UTF-8 bytes one per transfer, in order. rsp_run_last marks the
// final byte caused by a request and rsp_string_end marks the terminating
// zero byte produced by a zero code unit.
// A high surrogate produces no byte until the next request arrives; a pair
// then gives four bytes, and otherwise the held unit is flushed as three.
// When the queue is empty and the result side is free, an accepted request is
// written into the job queue and then loaded into the output register, which
// presents its first byte. The result channel moves one byte per cycle while
// rsp_ready is high, and a request produces up to six bytes.
// Requests are taken in back-to-back cycles while the job queue between the
// front end and the byte emitter has room; the queue holds QUEUE_DEPTH jobs.
// When the receiver stalls, the output register holds its byte, the queue
// fills and req_ready drops; no byte is lost or repeated.
// Reset clears the held surrogate, the queue and the output valid flag.
`default_nettype none

module utf16_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [u16u8_pkg::UNIT_W-1:0]  req_code_unit,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [u16u8_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                               rsp_run_last,
   output logic                               rsp_string_end
);

   logic               q_full;
   logic               accept;
   logic               fe_job_valid;
   u16u8_pkg::job_type fe_job;
   logic               q_valid;
   u16u8_pkg::job_type q_job;
   logic               q_pop;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   u16u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .code_unit (req_code_unit),
      .job_valid (fe_job_valid),
      .job       (fe_job)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fe_job_valid),
      .wr_job   (fe_job),
      .full     (q_full),
      .rd_pop   (q_pop),
      .rd_valid (q_valid),
      .rd_job   (q_job)
   );

   u16u8_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (q_valid),
      .job            (q_job),
      .job_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule

`default_nettype wire

// ===== rtl/core/u16u8_queue.sv =====
// Short request queue between the classifying front end and the byte emitter.
`default_nettype none
`include "utf16_to_utf8_transcoder_macros.svh"

module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   input  wire u16u8_pkg::job_type wr_job,
   output logic                   full,
   input  wire logic              rd_pop,
   output logic                   rd_valid,
   output u16u8_pkg::job_type     rd_job
);

   // DEPTH must be a power of two of at least two, so the pointers wrap naturally; the queue does not enforce it.
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   u16u8_pkg::job_type job_mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = job_mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !full;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         job_mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `U16U8_ASSERT_NEVER(a_wr_when_full, clock, reset, wr_valid && full)
   `U16U8_ASSERT_NEVER(a_pop_when_empty, clock, reset, rd_pop && !rd_valid)
   `U16U8_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

// ===== rtl/core/u16u8_front.sv =====
// Front end: holds a pending high surrogate and turns the code units into byte jobs.
`default_nettype none

module u16u8_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic [u16u8_pkg::UNIT_W-1:0]    code_unit,
   output logic                                 job_valid,
   output u16u8_pkg::job_type                   job
);

   typedef enum logic [2:0] {
      CLS_END,
      CLS_ONE,
      CLS_TWO,
      CLS_HIGH,
      CLS_THREE
   } unit_class_type;

   logic [u16u8_pkg::UNIT_W-1:0] held_ff, held_in;
   logic                         pending_ff, pending_in;
   logic                         is_low, is_high, pair;
   unit_class_type               cls;
   logic [2:0][u16u8_pkg::BYTE_W-1:0] nb;
   logic [2:0][u16u8_pkg::BYTE_W-1:0] flush;
   logic [u16u8_pkg::JOB_CNT_W-1:0]   ncnt;
   logic                              nend;
   logic [20:0]                       cp;

   assign is_low  = (code_unit[15:10] == 6'b110111);
   assign is_high = (code_unit[15:10] == 6'b110110);
   assign pair    = pending_ff && is_low;
   assign cp      = 21'h10000 + {1'b0, held_ff[9:0], code_unit[9:0]};

   always_comb begin
      if (code_unit == '0) begin
         cls = CLS_END;
      end else if (code_unit[15:7] == '0) begin
         cls = CLS_ONE;
      end else if (code_unit[15:11] == '0) begin
         cls = CLS_TWO;
      end else if (is_high) begin
         cls = CLS_HIGH;
      end else begin
         cls = CLS_THREE;
      end
   end

   always_comb begin
      nb   = '0;
      ncnt = '0;
      nend = 1'b0;
      unique case (cls)
         CLS_END: begin
            nb[0] = u16u8_pkg::NUL_BYTE;
            ncnt  = 3'd1;
            nend  = 1'b1;
         end
         CLS_ONE: begin
            nb[0] = code_unit[7:0];
            ncnt  = 3'd1;
         end
         CLS_TWO: begin
            nb[0] = u16u8_pkg::LEAD_TWO | {3'b000, code_unit[10:6]};
            nb[1] = u16u8_pkg::CONT_BYTE | {2'b00, code_unit[5:0]};
            ncnt  = 3'd2;
         end
         CLS_HIGH: begin
            ncnt = '0;
         end
         CLS_THREE: begin
            nb[0] = u16u8_pkg::LEAD_THREE | {4'h0, code_unit[15:12]};
            nb[1] = u16u8_pkg::CONT_BYTE | {2'b00, code_unit[11:6]};
            nb[2] = u16u8_pkg::CONT_BYTE | {2'b00, code_unit[5:0]};
            ncnt  = 3'd3;
         end
         default: begin
            ncnt = '0;
         end
      endcase
   end

   always_comb begin
      flush[0] = u16u8_pkg::LEAD_THREE | {4'h0, held_ff[15:12]};
      flush[1] = u16u8_pkg::CONT_BYTE | {2'b00, held_ff[11:6]};
      flush[2] = u16u8_pkg::CONT_BYTE | {2'b00, held_ff[5:0]};
   end

   always_comb begin
      job = '0;
      if (pair) begin
         job.bytes[0] = u16u8_pkg::LEAD_FOUR | {5'b00000, cp[20:18]};
         job.bytes[1] = u16u8_pkg::CONT_BYTE | {2'b00, cp[17:12]};
         job.bytes[2] = u16u8_pkg::CONT_BYTE | {2'b00, cp[11:6]};
         job.bytes[3] = u16u8_pkg::CONT_BYTE | {2'b00, cp[5:0]};
         job.cnt      = 3'd4;
      end else if (pending_ff) begin
         job.bytes[0] = flush[0];
         job.bytes[1] = flush[1];
         job.bytes[2] = flush[2];
         job.bytes[3] = nb[0];
         job.bytes[4] = nb[1];
         job.bytes[5] = nb[2];
         job.cnt      = 3'd3 + ncnt;
         job.str_end  = nend;
      end else begin
         job.bytes[0] = nb[0];
         job.bytes[1] = nb[1];
         job.bytes[2] = nb[2];
         job.cnt      = ncnt;
         job.str_end  = nend;
      end
   end

   assign job_valid = accept && (job.cnt != '0);

   always_comb begin
      pending_in = pending_ff;
      held_in    = held_ff;
      if (accept) begin
         pending_in = !pair && is_high;
         held_in    = (!pair && is_high) ? code_unit : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         held_ff    <= '0;
      end else begin
         pending_ff <= pending_in;
         held_ff    <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/u16u8_back.sv =====
// Back end: walks a byte job and presents one byte per cycle in the output register while the receiver is ready.
`default_nettype none
`include "utf16_to_utf8_transcoder_macros.svh"

module u16u8_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         job_valid,
   input  wire u16u8_pkg::job_type           job,
   output logic                              job_pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [u16u8_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                              rsp_run_last,
   output logic                              rsp_string_end
);

   logic [u16u8_pkg::JOB_CNT_W-1:0] idx_ff, idx_in;
   logic                            valid_ff, valid_in;
   logic [u16u8_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic                            last_ff, last_in;
   logic                            end_ff, end_in;
   logic                            load, is_last;

   assign load    = job_valid && (!valid_ff || rsp_ready);
   assign is_last = (idx_ff == job.cnt - 1'b1);
   assign job_pop = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = job.bytes[idx_ff];
         last_in  = is_last;
         end_in   = is_last && job.str_end;
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      end_ff  <= end_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_string_end = end_ff;

   `U16U8_ASSERT_IMPLIES(a_idx_in_job, clock, reset, job_valid, idx_ff < job.cnt)
   `U16U8_ASSERT_IMPLIES(a_end_is_last, clock, reset, valid_ff && end_ff, last_ff)
   `U16U8_ASSERT_IMPLIES(a_end_is_nul, clock, reset, valid_ff && end_ff, byte_ff == '0)

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 transcoder with randomized flow control.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [u16u8_pkg::BYTE_W-1:0] value;
      logic                         run_last;
      logic                         string_end;
   } utf8_byte_type;

   class utf8_scoreboard;
      utf8_byte_type                expected_bytes[$];
      logic [u16u8_pkg::UNIT_W-1:0] held_unit;
      bit                           held_valid;
      int unsigned                  failures;

      function new();
         held_unit = '0;
         held_valid = 1'b0;
         failures = 0;
      endfunction

      function int waiting();
         return expected_bytes.size();
      endfunction

      function void push_byte(logic [u16u8_pkg::BYTE_W-1:0] value, logic string_end);
         utf8_byte_type b;
         b.value = value;
         b.run_last = 1'b0;
         b.string_end = string_end;
         expected_bytes.push_back(b);
      endfunction

      function void push_three(logic [u16u8_pkg::UNIT_W-1:0] unit);
         push_byte(u16u8_pkg::LEAD_THREE | {4'h0, unit[15:12]}, 1'b0);
         push_byte(u16u8_pkg::CONT_BYTE | {2'b00, unit[11:6]}, 1'b0);
         push_byte(u16u8_pkg::CONT_BYTE | {2'b00, unit[5:0]}, 1'b0);
      endfunction

      function void note_unit(logic [u16u8_pkg::UNIT_W-1:0] unit);
         int            start_size;
         logic [20:0]   code_point;
         utf8_byte_type tail;
         start_size = expected_bytes.size();
         if (held_valid && unit[15:10] == 6'b110111) begin
            code_point = 21'h10000 + {1'b0, held_unit[9:0], 10'b0} + {11'b0, unit[9:0]};
            push_byte(u16u8_pkg::LEAD_FOUR | {5'b0, code_point[20:18]}, 1'b0);
            push_byte(u16u8_pkg::CONT_BYTE | {2'b00, code_point[17:12]}, 1'b0);
            push_byte(u16u8_pkg::CONT_BYTE | {2'b00, code_point[11:6]}, 1'b0);
            push_byte(u16u8_pkg::CONT_BYTE | {2'b00, code_point[5:0]}, 1'b0);
            held_valid = 1'b0;
            held_unit = '0;
         end else begin
            if (held_valid) begin
               push_three(held_unit);
               held_valid = 1'b0;
               held_unit = '0;
            end
            if (unit == '0) begin
               push_byte(u16u8_pkg::NUL_BYTE, 1'b1);
            end else if (unit[15:7] == '0) begin
               push_byte(unit[7:0], 1'b0);
            end else if (unit[15:11] == '0) begin
               push_byte(u16u8_pkg::LEAD_TWO | {3'b000, unit[10:6]}, 1'b0);
               push_byte(u16u8_pkg::CONT_BYTE | {2'b00, unit[5:0]}, 1'b0);
            end else if (unit[15:10] == 6'b110110) begin
               held_unit = unit;
               held_valid = 1'b1;
            end else begin
               push_three(unit);
            end
         end
         if (expected_bytes.size() > start_size) begin
            tail = expected_bytes.pop_back();
            tail.run_last = 1'b1;
            expected_bytes.push_back(tail);
         end
      endfunction

      function void check_byte(logic [u16u8_pkg::BYTE_W-1:0] value, logic run_last,
                               logic string_end);
         utf8_byte_type want;
         if (expected_bytes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%t: unexpected byte %h last=%b end=%b",
                        $realtime, value, run_last, string_end);
         end else begin
            want = expected_bytes.pop_front();
            if (want.value !== value || want.run_last !== run_last
                || want.string_end !== string_end) begin
               failures++;
               if (failures <= 10)
                  $display("%t: byte error: expected %h last=%b end=%b, got %h last=%b end=%b",
                           $realtime, want.value, want.run_last, want.string_end,
                           value, run_last, string_end);
            end
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [u16u8_pkg::UNIT_W-1:0]   req_code_unit = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [u16u8_pkg::BYTE_W-1:0]   rsp_out_byte;
   logic                           rsp_run_last;
   logic                           rsp_string_end;

   utf8_scoreboard sb = new();

   int stalls_asked = 0;
   int stalls_done = 0;
   int hold_left = 0;
   int ready_gap = 0;
   int calm_left = 0;
   int ready_roll;
   int sent_units = 0;

   utf16_to_utf8_transcoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_unit  (req_code_unit),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_byte(rsp_out_byte, rsp_run_last, rsp_string_end);
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stalls_done < stalls_asked) begin
         stalls_done++;
         hold_left = 80;
         rsp_ready <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_ready <= 1'b1;
      end else if (ready_gap > 0) begin
         ready_gap--;
         rsp_ready <= 1'b0;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 5) begin
            calm_left = $urandom_range(20, 60);
            rsp_ready <= 1'b1;
         end else if (ready_roll < 60) begin
            rsp_ready <= 1'b1;
         end else if (ready_roll < 95) begin
            ready_gap = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            ready_gap = $urandom_range(5, 25);
            rsp_ready <= 1'b0;
         end
      end
   end

   task automatic send_unit(input logic [u16u8_pkg::UNIT_W-1:0] unit);
      req_valid <= 1'b1;
      req_code_unit <= unit;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_unit(unit);
      sent_units++;
   endtask

   task automatic sender_gap();
      int roll;
      int cycles;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         cycles = 0;
      else if (roll < 90)
         cycles = $urandom_range(1, 3);
      else
         cycles = $urandom_range(5, 30);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.waiting() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_text();
      int                           kind;
      logic [u16u8_pkg::UNIT_W-1:0] unit;
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
         send_unit(u16u8_pkg::UNIT_W'($urandom_range(1, 16'h007F)));
      end else if (kind < 35) begin
         send_unit(u16u8_pkg::UNIT_W'($urandom_range(16'h0080, 16'h07FF)));
      end else if (kind < 55) begin
         unit = u16u8_pkg::UNIT_W'($urandom_range(16'h0800, 16'hFFFF));
         if (unit[15:11] == 5'b11011)
            unit = unit ^ 16'h2000;
         send_unit(unit);
      end else if (kind < 80) begin
         send_unit(16'hD800 | u16u8_pkg::UNIT_W'($urandom_range(0, 16'h03FF)));
         sender_gap();
         send_unit(16'hDC00 | u16u8_pkg::UNIT_W'($urandom_range(0, 16'h03FF)));
      end else if (kind < 85) begin
         send_unit('0);
      end else if (kind < 90) begin
         send_unit(16'hD800 | u16u8_pkg::UNIT_W'($urandom_range(0, 16'h03FF)));
      end else if (kind < 95) begin
         send_unit(16'hDC00 | u16u8_pkg::UNIT_W'($urandom_range(0, 16'h03FF)));
      end else begin
         send_unit(u16u8_pkg::UNIT_W'($urandom()));
      end
   endtask

   initial begin
      logic [u16u8_pkg::UNIT_W-1:0] directed_units[$];
      bit                           burst_done;
      bit                           drain_done;
      directed_units = '{16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
                         16'hFFFF, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hD800,
                         16'h0041, 16'hDBC0, 16'hD801, 16'h07FF, 16'hDC00, 16'hD83D,
                         16'hE000, 16'hDA00, 16'h0000, 16'h5555, 16'hAAAA};
      burst_done = 1'b0;
      drain_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_units[i])
         send_unit(directed_units[i]);
      wait_for_drain();

      sent_units = 0;
      while (sent_units < 200) begin
         if (!burst_done && sent_units >= 60) begin
            burst_done = 1'b1;
            stalls_asked++;
            repeat (12)
               send_unit(16'h0800 | u16u8_pkg::UNIT_W'($urandom_range(0, 16'h4FFF)));
         end else if (!drain_done && sent_units >= 120) begin
            drain_done = 1'b1;
            wait_for_drain();
         end else begin
            sender_gap();
            send_random_text();
         end
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (sb.failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
